[sv/lmmwf_pkg.sv]
package lmmwf_pkg;

  localparam int K_LIMIT    = 63;
  localparam int PIXEL_BITS = 16;
  localparam int K_BITS     = 6;

  localparam int RADIUS_MAX = K_LIMIT / 2;
  localparam int WIN_MAX    = 2 * RADIUS_MAX + 1;
  localparam int NUM_LEVELS = $clog2(WIN_MAX + 1);
  localparam int LEN_BITS   = NUM_LEVELS;
  localparam int LVL_BITS   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int RING_AW    = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int RAD_BITS   = (RADIUS_MAX > 0) ? $clog2(RADIUS_MAX + 1) : 1;

  localparam int POS_BITS = 8;
  localparam int POS_CAP  = (1 << POS_BITS) - 1;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = K_BITS;

  localparam int WINDOW_SIZE_RESET = 3;
  localparam int DILATE_MODE_RESET = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_DILATE_MODE = 1'b1
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef logic [NUM_LEVELS-1:0][PIXEL_BITS-1:0] lvl_set_t;

  // Level j holds the extremum of the 2**j pixels ending at the entry's position.
  typedef struct packed {
    lvl_set_t hi;
    lvl_set_t lo;
  } lvl_entry_t;

endpackage

[sv/lmmwf_if.sv]
interface lmmwf_in_if;
  logic                valid;
  logic                ready;
  lmmwf_pkg::pixel_t   pixel_in;
  logic                line_end;

  modport source (output valid, output pixel_in, output line_end, input ready);
  modport sink (input valid, input pixel_in, input line_end, output ready);
endinterface

interface lmmwf_out_if;
  logic                valid;
  logic                ready;
  lmmwf_pkg::pixel_t   pixel_out;
  logic                last_out;

  modport source (output valid, output pixel_out, output last_out, input ready);
  modport sink (input valid, input pixel_out, input last_out, output ready);
endinterface

[sv/line_min_max_window_filter_top.sv]
// Pipeline: a result is registered in stage 1 and then in the output register after the transfer
// of the pixel that closes its window; the further results that a line-end pixel flushes follow
// the first one in order.
// Throughput: one pixel per cycle while the output is not stalled; a line-end pixel with pending
// results holds off input while the flush sequencer issues one level-table read per cycle.
// Reset (rst_n low, synchronous) clears the line and flush control and the output valid
// and loads the register defaults; the level table and delay lines are undefined until written.
module line_min_max_window_filter_top (
  input  logic                                      clk,
  input  logic                                      rst_n,
  lmmwf_in_if.sink                                  in_ch,
  lmmwf_out_if.source                               out_ch,
  input  logic                                      cfg_we,
  input  logic [lmmwf_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [lmmwf_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  function automatic lmmwf_pkg::pixel_t pick(input logic dil, input lmmwf_pkg::pixel_t a,
                                             input lmmwf_pkg::pixel_t b);
    lmmwf_pkg::pixel_t res;
    if (dil) begin
      res = (a > b) ? a : b;
    end else begin
      res = (a < b) ? a : b;
    end
    return res;
  endfunction

  function automatic logic [lmmwf_pkg::LEN_BITS-1:0] clip_hi(
      input logic [lmmwf_pkg::POS_BITS:0] a, input logic [lmmwf_pkg::POS_BITS-1:0] p);
    logic [lmmwf_pkg::POS_BITS:0] res;
    res = (a > {1'b0, p}) ? {1'b0, p} : a;
    return res[lmmwf_pkg::LEN_BITS-1:0];
  endfunction

  logic [lmmwf_pkg::K_BITS-1:0]     window_size_r;
  logic                             dilate_r;
  logic [lmmwf_pkg::RAD_BITS-1:0]   radius;

  logic [lmmwf_pkg::POS_BITS-1:0]   p_r;
  logic [lmmwf_pkg::POS_BITS-1:0]   pend_r;
  logic [lmmwf_pkg::RING_AW-1:0]    wptr_r;
  logic                             flush_r;
  logic [lmmwf_pkg::RAD_BITS-1:0]   d_r;

  lmmwf_pkg::lvl_entry_t            ring_mem [lmmwf_pkg::RING_DEPTH];
  lmmwf_pkg::lvl_entry_t            rd_r;
  lmmwf_pkg::lvl_entry_t            cur;
  lmmwf_pkg::lvl_entry_t            newest_r;
  lmmwf_pkg::lvl_entry_t            newest;
  lmmwf_pkg::pixel_t                tap_hi [lmmwf_pkg::NUM_LEVELS-1];
  lmmwf_pkg::pixel_t                tap_lo [lmmwf_pkg::NUM_LEVELS-1];

  logic                             accept;
  logic                             advance;
  logic                             s1_free;

  logic                             iss_valid;
  logic                             iss_last;
  logic [lmmwf_pkg::LEN_BITS-1:0]   iss_hi;
  logic [lmmwf_pkg::LEN_BITS-1:0]   iss_len;
  logic [lmmwf_pkg::LEN_BITS-1:0]   iss_off;
  logic [lmmwf_pkg::LVL_BITS-1:0]   iss_lvl;
  logic [lmmwf_pkg::RING_AW-1:0]    newest_addr;
  logic [lmmwf_pkg::RING_AW-1:0]    rd_addr;
  logic [lmmwf_pkg::RAD_BITS-1:0]   d_start;

  logic                             s1_valid_r;
  logic                             s1_last_r;
  logic                             s1_self_r;
  logic [lmmwf_pkg::LVL_BITS-1:0]   s1_lvl_r;
  lmmwf_pkg::pixel_t                s1_pix_r;
  lmmwf_pkg::pixel_t                rd_pix;
  lmmwf_pkg::pixel_t                res_pix;

  logic                             out_valid_r;
  lmmwf_pkg::pixel_t                out_pixel_r;
  logic                             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= lmmwf_pkg::K_BITS'(lmmwf_pkg::WINDOW_SIZE_RESET);
      dilate_r      <= 1'(lmmwf_pkg::DILATE_MODE_RESET);
    end else if (cfg_we) begin
      unique case (lmmwf_pkg::cfg_reg_t'(cfg_index))
        lmmwf_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_data[lmmwf_pkg::K_BITS-1:0];
        lmmwf_pkg::CFG_DILATE_MODE: dilate_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    int k_sat;
    k_sat = int'(window_size_r);
    if (k_sat > lmmwf_pkg::K_LIMIT) begin
      k_sat = lmmwf_pkg::K_LIMIT;
    end
    radius = lmmwf_pkg::RAD_BITS'(k_sat >> 1);
  end

  assign advance   = ~out_valid_r | out_ch.ready;
  assign s1_free   = ~s1_valid_r | advance;
  assign in_ch.ready = s1_free & ~flush_r;
  assign accept    = in_ch.valid & in_ch.ready;

  for (genvar j = 0; j < lmmwf_pkg::NUM_LEVELS - 1; j++) begin : g_delay
    lmmwf_pkg::pixel_t dl_hi [1 << j];
    lmmwf_pkg::pixel_t dl_lo [1 << j];

    always_ff @(posedge clk) begin
      if (accept) begin
        dl_hi[0] <= cur.hi[j];
        dl_lo[0] <= cur.lo[j];
        for (int i = 1; i < (1 << j); i++) begin
          dl_hi[i] <= dl_hi[i-1];
          dl_lo[i] <= dl_lo[i-1];
        end
      end
    end

    assign tap_hi[j] = dl_hi[(1 << j) - 1];
    assign tap_lo[j] = dl_lo[(1 << j) - 1];
  end

  always_comb begin
    cur.hi[0] = in_ch.pixel_in;
    cur.lo[0] = in_ch.pixel_in;
    for (int j = 1; j < lmmwf_pkg::NUM_LEVELS; j++) begin
      cur.hi[j] = pick(1'b1, cur.hi[j-1], tap_hi[j-1]);
      cur.lo[j] = pick(1'b0, cur.lo[j-1], tap_lo[j-1]);
    end
  end

  always_comb begin
    iss_valid   = 1'b0;
    iss_last    = 1'b0;
    iss_hi      = '0;
    newest      = newest_r;
    newest_addr = wptr_r - 1'b1;
    d_start     = (p_r < lmmwf_pkg::POS_BITS'(radius)) ? lmmwf_pkg::RAD_BITS'(p_r) : radius;
    if (accept) begin
      newest      = cur;
      newest_addr = wptr_r;
      if (in_ch.line_end) begin
        iss_valid = 1'b1;
        iss_last  = (d_start == '0);
        iss_hi    = clip_hi((lmmwf_pkg::POS_BITS+1)'(d_start) +
                            (lmmwf_pkg::POS_BITS+1)'(radius), p_r);
      end else begin
        iss_valid = (p_r >= lmmwf_pkg::POS_BITS'(radius));
        iss_hi    = clip_hi((lmmwf_pkg::POS_BITS+1)'(radius) << 1, p_r);
      end
    end else if (flush_r && s1_free) begin
      iss_valid = 1'b1;
      iss_last  = (d_r == '0);
      iss_hi    = clip_hi((lmmwf_pkg::POS_BITS+1)'(d_r) +
                          (lmmwf_pkg::POS_BITS+1)'(radius), pend_r);
    end
  end

  // A window of length n ending at the newest pixel is the union of two overlapping
  // power-of-two spans: one ending at the newest pixel and one ending n - 2**j earlier.
  always_comb begin
    iss_len = iss_hi + 1'b1;
    iss_lvl = '0;
    for (int b = 0; b < lmmwf_pkg::LEN_BITS; b++) begin
      if (iss_len[b]) begin
        iss_lvl = lmmwf_pkg::LVL_BITS'(b);
      end
    end
    iss_off = iss_len & ~(lmmwf_pkg::LEN_BITS'(1) << iss_lvl);
    rd_addr = newest_addr - iss_off[lmmwf_pkg::RING_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[wptr_r] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && iss_valid) begin
      rd_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r     <= '0;
      pend_r  <= '0;
      wptr_r  <= '0;
      flush_r <= 1'b0;
      d_r     <= '0;
    end else if (accept) begin
      wptr_r <= wptr_r + 1'b1;
      if (in_ch.line_end) begin
        p_r <= '0;
        if (d_start != '0) begin
          flush_r <= 1'b1;
          d_r     <= d_start - 1'b1;
          pend_r  <= p_r;
        end
      end else if (p_r != lmmwf_pkg::POS_BITS'(lmmwf_pkg::POS_CAP)) begin
        p_r <= p_r + 1'b1;
      end
    end else if (flush_r && s1_free) begin
      if (d_r == '0) begin
        flush_r <= 1'b0;
      end else begin
        d_r <= d_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newest_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && iss_valid) begin
      s1_pix_r  <= dilate_r ? newest.hi[iss_lvl] : newest.lo[iss_lvl];
      s1_lvl_r  <= iss_lvl;
      s1_self_r <= (iss_off == '0);
      s1_last_r <= iss_last;
    end
  end

  assign rd_pix  = dilate_r ? rd_r.hi[s1_lvl_r] : rd_r.lo[s1_lvl_r];
  assign res_pix = s1_self_r ? s1_pix_r : pick(dilate_r, s1_pix_r, rd_pix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pixel_r <= res_pix;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pixel_r;
  assign out_ch.last_out  = out_last_r;

endmodule

[sv/lmmwf_checker.sv]
module lmmwf_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    line_end,
  input logic                    out_valid,
  input logic                    out_ready,
  input lmmwf_pkg::pixel_t       pixel_out,
  input logic                    last_out
);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] end_cnt_r;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // Counts line-end pixels whose final result has not been transferred yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_cnt_r <= '0;
    end else begin
      end_cnt_r <= end_cnt_r + 4'(in_xfer && line_end) - 4'(out_xfer && last_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_out))
    else $error("stalled result changed or dropped");

  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({out_valid, in_ready}))
    else $error("handshake signal unknown");

  a_last_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && last_out |-> end_cnt_r != '0)
    else $error("line-final result without a line-end pixel");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind line_min_max_window_filter_top lmmwf_checker u_lmmwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .line_end  (in_ch.line_end),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .last_out  (out_ch.last_out)
);
